>>> hw/rtl/lsa_pkg.sv
// lsa_pkg: shared types and constants for the latency statistics accumulator.
// Used by lsa_ser_div and latency_stats_accumulator_unit.
`timescale 1ns / 1ps

package lsa_pkg;

  // Field widths
  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int STAT_W  = 32;
  // Signed latency product: 33-bit seconds difference times 20-bit constant
  localparam int DIFF_W  = 54;
  localparam int TOTAL_W = 2 * STAT_W;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 160;

  localparam logic [USEC_W-1:0] US_PER_SECOND = USEC_W'(1000000);
  localparam logic [STAT_W-1:0] ALL_ONES      = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WRITE
  } lsa_state_t;

endpackage

>>> hw/rtl/lsa_ser_mul.sv
// lsa_ser_mul: shift-add multiplier, one bit of the multiplier per cycle.
// Standalone; the top level sizes it through parameters.
`timescale 1ns / 1ps

module lsa_ser_mul #(
  parameter int P_W = 64,
  parameter int B_W = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [P_W-1:0] a,
  input  logic [B_W-1:0] b,
  input  logic [P_W-1:0] init,
  output logic [P_W-1:0] product,
  output logic           done
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   a_r, a_nxt;
  logic [B_W-1:0]   b_r, b_nxt;
  logic [P_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Load on start, then add the shifted multiplicand per set multiplier bit
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (start) begin
      a_nxt   = a;
      b_nxt   = b;
      acc_nxt = init;
      cnt_nxt = CNT_W'(B_W);
    end else if (cnt_r != '0) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt   = {a_r[P_W-2:0], 1'b0};
      b_nxt   = {1'b0, b_r[B_W-1:1]};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign product = acc_r;
  assign done    = (cnt_r == '0);

endmodule

>>> hw/rtl/lsa_ser_div.sv
// lsa_ser_div: restoring divider, one quotient bit per cycle.
// Needs lsa_pkg; the upper half of the dividend must be below the divisor.
`timescale 1ns / 1ps

module lsa_ser_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lsa_pkg::TOTAL_W-1:0]   dividend,
  input  logic [lsa_pkg::STAT_W:0]      divisor,
  output logic [lsa_pkg::STAT_W-1:0]    quotient,
  output logic                          done
);

  import lsa_pkg::*;

  localparam int CNT_W = $clog2(STAT_W + 1);

  logic [STAT_W:0]   rem_r, rem_nxt;
  logic [STAT_W-1:0] q_r, q_nxt;
  logic [STAT_W:0]   dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STAT_W+1:0] shifted;
  logic [STAT_W+1:0] trial;

  // Shift in one dividend bit, subtract the divisor where it fits
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    shifted = {rem_r, q_r[STAT_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    if (start) begin
      rem_nxt = {1'b0, dividend[TOTAL_W-1:STAT_W]};
      q_nxt   = dividend[STAT_W-1:0];
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(STAT_W);
    end else if (cnt_r != '0) begin
      if (!trial[STAT_W+1]) begin
        rem_nxt = trial[STAT_W:0];
        q_nxt   = {q_r[STAT_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[STAT_W:0];
        q_nxt   = {q_r[STAT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = q_r;
  assign done     = (cnt_r == '0);

endmodule

>>> hw/rtl/latency_stats_accumulator_unit.sv
// latency_stats_accumulator_unit: running min/max/mean/count of packet latency.
// Needs lsa_pkg, lsa_ser_mul and lsa_ser_div.
`timescale 1ns / 1ps
//
//  channel | direction | payload (lowest bits first)
//  in_*    | request   | start_seconds, start_micros, end_seconds, end_micros
//  out_*   | result    | latency_us, min_latency_us, max_latency_us,
//          |           | mean_latency_us, sample_count
//
// Steps of a request: accept, the serial multiply of mean by count (the
// seconds-times-10^6 multiply runs beside it), the bit-serial division, and
// the write of the result. Reset is synchronous and active low. A new request
// is accepted while a result waits on out_tready; a stalled result holds the
// block in its write step.

module latency_stats_accumulator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_seconds[31:0], start_micros[51:32], end_seconds[83:52], end_micros[103:84]
  input  logic [lsa_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // latency_us[31:0], min_latency_us[63:32], max_latency_us[95:64],
  // mean_latency_us[127:96], sample_count[159:128]
  output logic [lsa_pkg::OUT_DATA_W-1:0]    out_tdata
);

  import lsa_pkg::*;

  lsa_state_t state_r, state_nxt;

  logic [STAT_W-1:0] min_r, min_nxt;
  logic [STAT_W-1:0] max_r, max_nxt;
  logic [STAT_W-1:0] mean_r, mean_nxt;
  logic [STAT_W-1:0] count_r, count_nxt;
  logic [STAT_W-1:0] lat_r, lat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic              accept;
  logic [SEC_W-1:0]  start_seconds, end_seconds;
  logic [USEC_W-1:0] start_micros, end_micros;
  logic [SEC_W:0]    sec_diff;
  logic [USEC_W:0]   usec_diff;

  logic [DIFF_W-1:0]  diff_prod;
  logic               diff_done;
  logic [TOTAL_W-1:0] mc_prod;
  logic               mc_done;
  logic               div_start;
  logic [STAT_W-1:0]  quotient;
  logic               div_done;
  logic [STAT_W-1:0]  lat_sat;

  // Unpack the request
  assign start_seconds = in_tdata[31:0];
  assign start_micros  = in_tdata[51:32];
  assign end_seconds   = in_tdata[83:52];
  assign end_micros    = in_tdata[103:84];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Signed differences of the two timestamp parts
  assign sec_diff  = {1'b0, end_seconds} - {1'b0, start_seconds};
  assign usec_diff = {1'b0, end_micros} - {1'b0, start_micros};

  // Elapsed microseconds: seconds difference times 10^6, micros difference as start value
  lsa_ser_mul #(
    .P_W (DIFF_W),
    .B_W (USEC_W)
  ) u_lat_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .a       ({{(DIFF_W-SEC_W-1){sec_diff[SEC_W]}}, sec_diff}),
    .b       (US_PER_SECOND),
    .init    ({{(DIFF_W-USEC_W-1){usec_diff[USEC_W]}}, usec_diff}),
    .product (diff_prod),
    .done    (diff_done)
  );

  // Weighted old mean: mean times count
  lsa_ser_mul #(
    .P_W (TOTAL_W),
    .B_W (STAT_W)
  ) u_mc_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .a       ({{(TOTAL_W-STAT_W){1'b0}}, mean_r}),
    .b       (count_r),
    .init    ('0),
    .product (mc_prod),
    .done    (mc_done)
  );

  // Saturate negative or over-wide latency to all ones
  assign lat_sat = (diff_prod[DIFF_W-1] || (|diff_prod[DIFF_W-2:STAT_W])) ?
                   ALL_ONES : diff_prod[STAT_W-1:0];

  assign div_start = (state_r == ST_MUL) && mc_done && diff_done;

  // New mean: (mean*count + lat_sat) / (count + 1)
  lsa_ser_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mc_prod + {{(TOTAL_W-STAT_W){1'b0}}, lat_sat}),
    .divisor  ({1'b0, count_r} + {{STAT_W{1'b0}}, 1'b1}),
    .quotient (quotient),
    .done     (div_done)
  );

  // Sequence the request and update the statistics at write
  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    mean_nxt      = mean_r;
    count_nxt     = count_r;
    lat_nxt       = lat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (div_start) begin
          lat_nxt   = lat_sat;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_r || out_tready) begin
          if (lat_r < min_r) begin
            min_nxt = lat_r;
          end
          if (lat_r > max_r) begin
            max_nxt = lat_r;
          end
          if (count_r != ALL_ONES) begin
            count_nxt = count_r + STAT_W'(1);
          end
          mean_nxt      = quotient;
          out_data_nxt  = {count_nxt, mean_nxt, max_nxt, min_nxt, lat_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      min_r       <= ALL_ONES;
      max_r       <= '0;
      mean_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      mean_r      <= mean_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lat_r      <= lat_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
